// ===== rtl/core/ibs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibs_pkg
// shared types for the integer buffer sorter: data word, cell link, command
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  gt;
  } ibs_link_t;

  // control broadcast to the cell row
  typedef struct packed {
    logic ins;
    logic shift;
  } ibs_cmd_t;

endpackage

// ===== rtl/core/ibs_if.sv =====
// ----------------------------------------------------------------------------
// ibs_in_if / ibs_out_if
// valid/ready channels for input elements and sorted results
// ----------------------------------------------------------------------------
interface ibs_in_if;
  logic           valid;
  logic           ready;
  ibs_pkg::data_t value;
  logic           last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ibs_out_if;
  logic           valid;
  logic           ready;
  ibs_pkg::data_t sorted_value;
  logic           final_res;
  logic           overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

// ===== rtl/core/ibs_cell.sv =====
// ----------------------------------------------------------------------------
// ibs_cell
// one slot of the insertion row: holds a value, takes the new element, the
// left neighbor's value, or the right neighbor's value when draining
// ----------------------------------------------------------------------------
module ibs_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ibs_pkg::ibs_cmd_t    cmd,
  input  ibs_pkg::data_t       new_value,
  input  ibs_pkg::ibs_link_t   left_link,
  input  ibs_pkg::ibs_link_t   right_link,
  output ibs_pkg::ibs_link_t   own_link
);

  logic           valid_r;
  logic           valid_nxt;
  ibs_pkg::data_t value_r;
  ibs_pkg::data_t value_nxt;
  logic           new_lt;

  assign new_lt = valid_r && (new_value < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.shift) begin
      valid_nxt = right_link.valid;
      value_nxt = right_link.value;
    end else if (cmd.ins) begin
      if (left_link.gt) begin
        valid_nxt = left_link.valid;
        value_nxt = left_link.value;
      end else if ((!valid_r && left_link.valid) || new_lt) begin
        // only the first slot that is empty or holds a larger value takes the new element
        valid_nxt = 1'b1;
        value_nxt = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign own_link.valid = valid_r;
  assign own_link.value = value_r;
  assign own_link.gt    = new_lt;

endmodule

// ===== rtl/core/ibs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibs_ctrl
// run control: fill count, drop flag, load/drain phase, row commands
// ----------------------------------------------------------------------------
module ibs_ctrl #(
  parameter int SIZE  = 16,
  parameter int CNT_W = $clog2(SIZE + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               final_res,
  output logic               overflow,
  output ibs_pkg::ibs_cmd_t  cmd
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SIZE);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             drain_r;
  logic             drain_nxt;
  logic             dropped_r;
  logic             dropped_nxt;
  logic             in_fire;
  logic             out_fire;
  logic             full;

  assign in_ready  = !drain_r;
  assign out_valid = drain_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign full      = (count_r == FULL_CNT);
  assign final_res = (count_r == ONE_CNT);
  assign overflow  = dropped_r;

  assign cmd.ins   = in_fire && !full;
  assign cmd.shift = out_fire;

  always_comb begin
    count_nxt   = count_r;
    drain_nxt   = drain_r;
    dropped_nxt = dropped_r;
    if (in_fire) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + ONE_CNT;
      end
      if (in_last) begin
        drain_nxt = 1'b1;
      end
    end else if (out_fire) begin
      count_nxt = count_r - ONE_CNT;
      if (final_res) begin
        drain_nxt   = 1'b0;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      drain_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      drain_r   <= drain_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

// ===== rtl/core/integer_buffer_sorter.sv =====
// ----------------------------------------------------------------------------
// integer_buffer_sorter
// ascending sort of a run of signed integers in a row of insertion cells
//
//   channel | dir | fields                             | beat
//   in_bus  | in  | value, last                        | one element of a run
//   out_bus | out | sorted_value, final_res, overflow  | one sorted element
//
// load: one element per cycle, each inserted in place across the row in the
//   cycle it is taken; elements beyond SIZE are dropped and flagged
// drain: after the last beat, one result per cycle from cell 0 while the row
//   shifts left; in_bus.ready stays low until the final result is taken
// out_bus stalls freeze the row; reset empties the row
// ----------------------------------------------------------------------------
module integer_buffer_sorter #(
  parameter int SIZE = 16
) (
  input logic      clk,
  input logic      rst_n,
  ibs_in_if.sink   in_bus,
  ibs_out_if.source out_bus
);

  localparam int CNT_W = $clog2(SIZE + 1);

  ibs_pkg::ibs_cmd_t  cmd;
  ibs_pkg::ibs_link_t links [SIZE];

  ibs_ctrl #(
    .SIZE  (SIZE),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_last   (in_bus.last),
    .in_ready  (in_bus.ready),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .final_res (out_bus.final_res),
    .overflow  (out_bus.overflow),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    ibs_pkg::ibs_link_t left_l;
    ibs_pkg::ibs_link_t right_l;

    if (i == 0) begin : g_first
      // head of the row: an occupied slot that never shifts
      assign left_l = '{valid: 1'b1, value: '0, gt: 1'b0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end

    if (i == SIZE - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    ibs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_value  (in_bus.value),
      .left_link  (left_l),
      .right_link (right_l),
      .own_link   (links[i])
    );
  end

  assign out_bus.sorted_value = links[0].value;

endmodule
